### hdl/smcm_pkg.sv
// ----------------------------------------------------------------------------
// smcm_pkg
// Types, constants and helpers for the stereo output mix, clip and level meter.
// ----------------------------------------------------------------------------
package smcm_pkg;

  localparam int SMP_W      = 20;
  localparam int CLK_W      = 16;
  localparam int OUT_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 12;

  localparam int FRAME_MAX  = 4096;
  localparam int CNT_W      = $clog2(FRAME_MAX + 1);

  localparam int MAG_W      = OUT_W + 1;
  localparam int SQ_W       = 2 * (MAG_W - 1) + 1;
  localparam int SUM_W      = SQ_W + $clog2(FRAME_MAX);

  localparam int MUL_A_W    = SMP_W + 1;
  localparam int MUL_B_W    = GAIN_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int SCL_W      = PROD_W - FRAC_W + 1;

  localparam int RAD_W      = SQ_W + 1;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int RMD_W      = (CNT_W > ROOT_W + 1) ? CNT_W : ROOT_W + 1;
  localparam int SUB_W      = RMD_W + 2;
  localparam int ITER_W     = $clog2(SUM_W);

  localparam logic [GAIN_W-1:0]       GAIN_RESET  = GAIN_W'(4096);
  localparam logic                    METER_RESET = 1'b1;
  localparam logic signed [OUT_W-1:0] OUT_MAX     = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN     = 16'sh8000;

  typedef enum logic {
    CFG_OUTPUT_GAIN  = 1'b0,
    CFG_METER_ENABLE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic signed [SMP_W-1:0] in_left;
    logic signed [SMP_W-1:0] in_right;
    logic signed [CLK_W-1:0] click_sample;
    logic                    last_in_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_left;
    logic signed [OUT_W-1:0] out_right;
    logic                    frame_done;
    logic [OUT_W-1:0]        frame_peak;
    logic [OUT_W-1:0]        frame_rms;
    logic                    frame_clipped;
  } out_item_t;

  function automatic logic signed [OUT_W-1:0] sat_chan(
    input logic signed [PROD_W-1:0] prod,
    input logic signed [CLK_W-1:0]  click
  );
    logic signed [PROD_W-FRAC_W-1:0] q;
    logic signed [SCL_W-1:0]         s;
    logic signed [OUT_W-1:0]         r;
    q = prod[PROD_W-1:FRAC_W];
    s = SCL_W'(q) + SCL_W'(click);
    if (s > SCL_W'(OUT_MAX)) begin
      r = OUT_MAX;
    end else if (s < SCL_W'(OUT_MIN)) begin
      r = OUT_MIN;
    end else begin
      r = s[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/stereo_output_mix_clip_meter.sv
// ----------------------------------------------------------------------------
// stereo_output_mix_clip_meter
// Output gain, click mix, Q1.15 saturation and per-frame peak/RMS/clip meter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one stereo sample pair, a
//   click sample and an end-of-frame mark. Output channel (out_valid_o/
//   out_ready_i) returns one item per input: both saturated channels and,
//   on the item that closes a frame, peak and (with metering on) RMS and clip flag.
//   Configuration writes (cfg_valid_i/cfg_ready_o) are taken every cycle;
//   index 0 is the Q4.12 output gain, index 1 the meter enable.
// Timing:
//   One shared multiplier handles left gain, right gain and the square in
//   turn; a sample that does not close a frame then passes the accumulate
//   step to the done state. A closing sample adds a one-bit-per-cycle long
//   division of the square sum by the sample count and a two-bit-per-cycle
//   square root on one shared subtractor. One item is in work at a time;
//   in_ready_o is high only between items, so a new item is taken only
//   once the previous one has left the done state.
// Reset clears the frame accumulators, sets unity gain and metering on.
// A stalled receiver holds the result in the output register; the next item
// may be accepted meanwhile but its result waits until the register frees.
// ----------------------------------------------------------------------------
module stereo_output_mix_clip_meter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  smcm_pkg::in_item_t      in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output smcm_pkg::out_item_t     out_item_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  smcm_pkg::cfg_idx_e      cfg_index_i,
  input  logic [smcm_pkg::GAIN_W-1:0] cfg_data_i
);
  import smcm_pkg::*;

  seq_state_e state_q, state_d;

  logic [GAIN_W-1:0]       gain_q, gain_d;
  logic                    meter_q, meter_d;
  logic [OUT_W-1:0]        peak_q, peak_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    clip_q, clip_d;
  logic [ITER_W-1:0]       iter_q, iter_d;
  logic                    out_valid_q, out_valid_d;

  logic signed [SMP_W-1:0] left_q, left_d;
  logic signed [SMP_W-1:0] right_q, right_d;
  logic signed [CLK_W-1:0] click_q, click_d;
  logic                    last_q, last_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [OUT_W-1:0] ol_q, ol_d;
  logic signed [OUT_W-1:0] or_q, or_d;
  logic [RAD_W-1:0]        rad_q, rad_d;
  logic [ROOT_W-1:0]       root_q, root_d;
  logic [RMD_W-1:0]        rem_q, rem_d;
  out_item_t               out_q, out_d;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [SUB_W-1:0]          sub_a, sub_b;
  logic [SUB_W:0]            sub_diff;
  logic                      sub_ge;
  logic [MAG_W-1:0]          mag_l;
  logic signed [OUT_W-1:0]   sat_val;
  logic                      in_fire, out_load, close_now, div_last, sqrt_last;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign in_fire     = in_valid_i && in_ready_o;

  assign mag_l     = ol_q[OUT_W-1] ? (~MAG_W'(ol_q) + MAG_W'(1)) : MAG_W'(ol_q);
  assign sat_val   = sat_chan(prod_q, click_q);
  assign close_now = last_q || (count_q >= CNT_W'(FRAME_MAX));
  assign div_last  = (iter_q == ITER_W'(SUM_W - 1));
  assign sqrt_last = (iter_q == ITER_W'(SQRT_STEPS - 1));

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[SUB_W];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_MUL_L;
      ST_MUL_L:  state_d = ST_MUL_R;
      ST_MUL_R:  state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ACCUM;
      ST_ACCUM:  state_d = close_now ? ST_DIV : ST_DONE;
      ST_DIV:    if (div_last) state_d = ST_SQRT;
      ST_SQRT:   if (sqrt_last) state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a    = MUL_A_W'(left_q);
    mul_b    = MUL_B_W'($signed({1'b0, gain_q}));
    sub_a    = SUB_W'({rem_q[CNT_W-1:0], sum_q[SUM_W-1]});
    sub_b    = SUB_W'(count_q);
    out_load = 1'b0;
    case (state_q)
      ST_MUL_R: begin
        mul_a = MUL_A_W'(right_q);
      end
      ST_SQUARE: begin
        mul_a = MUL_A_W'($signed({1'b0, mag_l}));
        mul_b = MUL_B_W'($signed(mag_l));
      end
      ST_SQRT: begin
        sub_a = SUB_W'({rem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]});
        sub_b = SUB_W'({root_q, 2'b01});
      end
      ST_DONE: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    gain_d      = gain_q;
    meter_d     = meter_q;
    peak_d      = peak_q;
    sum_d       = sum_q;
    count_d     = count_q;
    clip_d      = clip_q;
    iter_d      = iter_q;
    left_d      = left_q;
    right_d     = right_q;
    click_d     = click_q;
    last_d      = last_q;
    prod_d      = prod_q;
    ol_d        = ol_q;
    or_d        = or_q;
    rad_d       = rad_q;
    root_d      = root_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OUTPUT_GAIN:  gain_d  = cfg_data_i;
        CFG_METER_ENABLE: meter_d = cfg_data_i[0];
        default: begin
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          left_d  = in_item_i.in_left;
          right_d = in_item_i.in_right;
          click_d = in_item_i.click_sample;
          last_d  = in_item_i.last_in_frame;
        end
      end
      ST_MUL_L: begin
        prod_d = PROD_W'(mul_a * mul_b);
      end
      ST_MUL_R: begin
        ol_d   = sat_val;
        prod_d = PROD_W'(mul_a * mul_b);
      end
      ST_SQUARE: begin
        or_d    = sat_val;
        prod_d  = PROD_W'(mul_a * mul_b);
        count_d = count_q + CNT_W'(1);
        if (mag_l > MAG_W'(peak_q)) peak_d = mag_l[OUT_W-1:0];
        if (ol_q == OUT_MAX || ol_q == OUT_MIN || sat_val == OUT_MAX || sat_val == OUT_MIN) begin
          clip_d = 1'b1;
        end
      end
      ST_ACCUM: begin
        sum_d  = sum_q + SUM_W'(prod_q[SQ_W-1:0]);
        last_d = close_now;
        iter_d = '0;
        rem_d  = '0;
      end
      ST_DIV: begin
        sum_d  = {sum_q[SUM_W-2:0], sub_ge};
        rem_d  = sub_ge ? sub_diff[RMD_W-1:0] : sub_a[RMD_W-1:0];
        iter_d = iter_q + ITER_W'(1);
        if (div_last) begin
          rad_d  = RAD_W'(sum_d[SQ_W-1:0]);
          rem_d  = '0;
          root_d = '0;
          iter_d = '0;
        end
      end
      ST_SQRT: begin
        rad_d  = {rad_q[RAD_W-3:0], 2'b00};
        rem_d  = sub_ge ? sub_diff[RMD_W-1:0] : sub_a[RMD_W-1:0];
        root_d = {root_q[ROOT_W-2:0], sub_ge};
        iter_d = iter_q + ITER_W'(1);
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d         = 1'b1;
          out_d.out_left      = ol_q;
          out_d.out_right     = or_q;
          out_d.frame_done    = last_q;
          out_d.frame_peak    = last_q ? peak_q : '0;
          out_d.frame_rms     = (last_q && meter_q) ? root_q[OUT_W-1:0] : '0;
          out_d.frame_clipped = last_q && meter_q && clip_q;
          if (last_q) begin
            peak_d  = '0;
            sum_d   = '0;
            count_d = '0;
            clip_d  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= GAIN_RESET;
      meter_q     <= METER_RESET;
      peak_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      clip_q      <= 1'b0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gain_q      <= gain_d;
      meter_q     <= meter_d;
      peak_q      <= peak_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      clip_q      <= clip_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    right_q <= right_d;
    click_q <= click_d;
    last_q  <= last_d;
    prod_q  <= prod_d;
    ol_q    <= ol_d;
    or_q    <= or_d;
    rad_q   <= rad_d;
    root_q  <= root_d;
    rem_q   <= rem_d;
    out_q   <= out_d;
  end

`ifndef SYNTHESIS
  a_quiet_meters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.frame_done |->
      out_item_o.frame_peak == '0 && out_item_o.frame_rms == '0 &&
      !out_item_o.frame_clipped)
    else $error("meter fields set on an item that does not close a frame");

  a_rms_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_done |->
      out_item_o.frame_rms <= out_item_o.frame_peak)
    else $error("frame RMS above frame peak");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FRAME_MAX))
    else $error("sample count beyond frame limit");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < RMD_W'(count_q) && count_q != '0)
    else $error("division remainder not below divisor");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q <= OUT_W'(32768))
    else $error("peak above full scale");
`endif

endmodule

### tb/tb_stereo_output_mix_clip_meter.sv
// ----------------------------------------------------------------------------
// tb_stereo_output_mix_clip_meter
// Self-checking bench for the stereo output mix, clip and level meter.
// Items go in through the valid/ready input channel and come back one per
// input. An in-bench model of gain, click mix, saturation and frame metering
// predicts each item, and each returned item is compared field by field.
// Directed corner items come first. Random framed traffic then runs under
// several gain and metering settings, with sender gaps and receiver stalls,
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_stereo_output_mix_clip_meter;
  import smcm_pkg::*;

  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 80;
  localparam int unsigned PHASE_ITEMS    = 300;

  class mix_meter_scoreboard;
    out_item_t         pending_outputs[$];
    logic [GAIN_W-1:0] gain;
    logic              meter_on;
    logic [OUT_W-1:0]  peak;
    logic [SUM_W-1:0]  sq_sum;
    logic [CNT_W-1:0]  count;
    logic              clip;
    int unsigned       errors;
    int unsigned       results_seen;

    function new();
      gain         = GAIN_RESET;
      meter_on     = METER_RESET;
      peak         = '0;
      sq_sum       = '0;
      count        = '0;
      clip         = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [GAIN_W-1:0] data);
      case (idx)
        CFG_OUTPUT_GAIN: begin
          gain = data;
        end
        CFG_METER_ENABLE: begin
          meter_on = data[0];
        end
        default: begin
        end
      endcase
    endfunction

    function logic signed [OUT_W-1:0] mix_channel(logic signed [SMP_W-1:0] smp,
                                                  logic signed [CLK_W-1:0] click);
      longint acc;
      acc = (longint'(smp) * longint'(gain)) >>> FRAC_W;
      acc = acc + longint'(click);
      if (acc > longint'(OUT_MAX)) return OUT_MAX;
      if (acc < longint'(OUT_MIN)) return OUT_MIN;
      return OUT_W'(acc);
    endfunction

    function logic [OUT_W-1:0] floor_root(logic [SUM_W-1:0] v);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 0;
      hi = 64'd1 << 22;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (mid * mid <= v) lo = mid;
        else hi = mid;
      end
      return OUT_W'(lo);
    endfunction

    function void note_input(in_item_t it);
      out_item_t               e;
      logic signed [OUT_W-1:0] l_out;
      logic signed [OUT_W-1:0] r_out;
      logic [MAG_W-1:0]        mag;
      logic                    closing;
      l_out = mix_channel(it.in_left, it.click_sample);
      r_out = mix_channel(it.in_right, it.click_sample);
      mag   = (l_out < 0) ? MAG_W'(-int'(l_out)) : MAG_W'(int'(l_out));
      if (mag > peak) peak = mag[OUT_W-1:0];
      sq_sum = sq_sum + SUM_W'(mag) * SUM_W'(mag);
      if (l_out == OUT_MAX || l_out == OUT_MIN || r_out == OUT_MAX || r_out == OUT_MIN) begin
        clip = 1'b1;
      end
      count   = count + 1'b1;
      closing = it.last_in_frame || (count >= FRAME_MAX);
      e           = '0;
      e.out_left  = l_out;
      e.out_right = r_out;
      if (closing) begin
        e.frame_done = 1'b1;
        e.frame_peak = peak;
        if (meter_on) begin
          e.frame_rms     = floor_root(sq_sum / SUM_W'(count));
          e.frame_clipped = clip;
        end
        peak   = '0;
        sq_sum = '0;
        count  = '0;
        clip   = 1'b0;
      end
      pending_outputs.push_back(e);
    endfunction

    function void compare_field(string field, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        if (errors <= 10) begin
          $display("Item %0d: %s expected %0d, got %0d", results_seen, field, exp_v, act_v);
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      results_seen++;
      if (pending_outputs.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Item %0d arrived with nothing expected: %h", results_seen, got);
        end
        return;
      end
      e = pending_outputs.pop_front();
      compare_field("out_left", e.out_left, got.out_left);
      compare_field("out_right", e.out_right, got.out_right);
      compare_field("frame_done", e.frame_done, got.frame_done);
      compare_field("frame_peak", e.frame_peak, got.frame_peak);
      compare_field("frame_rms", e.frame_rms, got.frame_rms);
      compare_field("frame_clipped", e.frame_clipped, got.frame_clipped);
    endfunction

    function int unsigned pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_idx_e          cfg_index = CFG_OUTPUT_GAIN;
  logic [GAIN_W-1:0] cfg_data  = '0;

  mix_meter_scoreboard sb;
  int unsigned         src_idle_pct   = 0;
  int unsigned         sink_stall_pct = 0;
  int unsigned         quiet_cycles   = 0;
  bit                  hold_req       = 1'b0;

  stereo_output_mix_clip_meter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        sb.write_register(cfg_index, cfg_data);
        quiet_cycles = 0;
      end
      if (in_valid && in_ready) begin
        sb.note_input(in_item);
        quiet_cycles = 0;
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_item);
        quiet_cycles = 0;
      end
    end
  end

  // hold off for a long stretch on request, else stall at random
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    wait (rst_n);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_item_t make_sample(int l, int r, int c, bit last);
    in_item_t it;
    it.in_left       = SMP_W'(l);
    it.in_right      = SMP_W'(r);
    it.click_sample  = CLK_W'(c);
    it.last_in_frame = last;
    return it;
  endfunction

  function automatic logic signed [SMP_W-1:0] random_level();
    case ($urandom_range(3))
      0: return SMP_W'($urandom);
      1: return SMP_W'(int'($urandom_range(65535)) - 32768);
      2: return SMP_W'(int'($urandom_range(4095)) - 2048);
      default: return SMP_W'(($urandom_range(1) ? 1 : -1) * int'($urandom_range(31744, 33791)));
    endcase
  endfunction

  function automatic logic signed [CLK_W-1:0] random_click();
    case ($urandom_range(2))
      0: return '0;
      1: return CLK_W'($urandom);
      default: return CLK_W'(int'($urandom_range(2047)) - 1024);
    endcase
  endfunction

  function automatic in_item_t random_sample();
    in_item_t it;
    it.in_left       = random_level();
    it.in_right      = random_level();
    it.click_sample  = random_click();
    it.last_in_frame = 1'b0;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_block_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [GAIN_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    bit          ragged;
    in_item_t    it;
    sent = 0;
    while (sent < n_items) begin
      ragged = ($urandom_range(9) == 0);
      len    = ($urandom_range(7) == 0) ? $urandom_range(120, 13) : $urandom_range(12, 1);
      for (int unsigned k = 0; k < len; k++) begin
        it = random_sample();
        it.last_in_frame = ragged ? 1'($urandom_range(1)) : (k == len - 1);
        send_item(it);
      end
      sent += len;
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: unity gain, metering on
    send_item(make_sample(0, 0, 0, 1'b1));
    send_item(make_sample(524287, -524288, 0, 1'b0));
    send_item(make_sample(-524288, 524287, -32768, 1'b0));
    send_item(make_sample(32767, 0, 0, 1'b0));
    send_item(make_sample(-32768, 0, 0, 1'b1));
    send_item(make_sample(100, 32767, 0, 1'b1));
    send_item(make_sample(1000, -1000, 32767, 1'b0));
    send_item(make_sample(-1000, 1000, -32768, 1'b0));
    send_item(make_sample(5, -5, 0, 1'b1));
    send_item(make_sample(3, -3, 2, 1'b1));
    wait_block_idle();
    write_reg(CFG_OUTPUT_GAIN, '0);
    write_reg(CFG_METER_ENABLE, GAIN_W'(0));
    send_item(make_sample(524287, -524288, 1234, 1'b0));
    send_item(make_sample(-1, -1, -32768, 1'b1));
    wait_block_idle();
    write_reg(CFG_OUTPUT_GAIN, '1);
    write_reg(CFG_METER_ENABLE, GAIN_W'(1));
    send_item(make_sample(-1, 1, 0, 1'b0));
    send_item(make_sample(3, -3, -1, 1'b0));
    send_item(make_sample(-524288, 8, 0, 1'b0));
    wait_block_idle();
    write_reg(CFG_METER_ENABLE, GAIN_W'(0));
    send_item(make_sample(7, -7, 100, 1'b0));
    wait_block_idle();
    write_reg(CFG_METER_ENABLE, GAIN_W'(1));
    send_item(make_sample(0, 0, 0, 1'b1));
    wait_block_idle();
    write_reg(CFG_METER_ENABLE, GAIN_W'(0));
    send_item(make_sample(20000, -20000, 0, 1'b0));
    send_item(make_sample(-20, 20, 0, 1'b1));
    wait_block_idle();

    write_reg(CFG_OUTPUT_GAIN, GAIN_RESET);
    write_reg(CFG_METER_ENABLE, GAIN_W'(1));

    write_reg(CFG_OUTPUT_GAIN, GAIN_W'($urandom_range(6144, 2048)));
    hold_req = 1'b1;
    run_frames(PHASE_ITEMS);
    wait_block_idle();

    write_reg(CFG_OUTPUT_GAIN, '1);
    write_reg(CFG_METER_ENABLE, GAIN_W'(0));
    src_idle_pct = 84;
    run_frames(PHASE_ITEMS);
    wait_block_idle();

    write_reg(CFG_OUTPUT_GAIN, GAIN_W'($urandom));
    write_reg(CFG_METER_ENABLE, GAIN_W'(1));
    src_idle_pct   = 0;
    sink_stall_pct = 84;
    run_frames(PHASE_ITEMS);
    wait_block_idle();

    write_reg(CFG_OUTPUT_GAIN, GAIN_W'(12288));
    src_idle_pct   = 13;
    sink_stall_pct = 13;
    run_frames(PHASE_ITEMS);
    wait_block_idle();

    write_reg(CFG_OUTPUT_GAIN, GAIN_W'(1));
    write_reg(CFG_METER_ENABLE, GAIN_W'(0));
    run_frames(PHASE_ITEMS / 3);
    wait_block_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hdl/smcm_pkg.sv
hdl/stereo_output_mix_clip_meter.sv
tb/tb_stereo_output_mix_clip_meter.sv
